FILE: rtl/ags_pkg.sv
// ----------------------------------------------------------------------------
// ags_pkg: shared types, constants and helpers of the affine gap scorer
// Score arithmetic is 16-bit wrapping; positions are carried at their widest.
// ----------------------------------------------------------------------------
package ags_pkg;

  localparam int QUERY_MAX_DEF   = 512;
  localparam int TARGET_MAX_DEF  = 1024;
  localparam int SYMBOL_BITS_DEF = 8;

  localparam int SCORE_W = 16;
  localparam int QPOS_W  = 12;
  localparam int TPOS_W  = 16;
  localparam int COUNT_W = 20;
  localparam int SYM_W   = 8;

  typedef logic signed [SCORE_W-1:0] score_t;

  localparam score_t NEG_FLOOR = -16'sd30000;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [2:0] {
    CFG_MATCH       = 3'd0,
    CFG_MISMATCH    = 3'd1,
    CFG_GAP_OPEN    = 3'd2,
    CFG_GAP_EXTEND  = 3'd3,
    CFG_START_CLIP  = 3'd4,
    CFG_END_CLIP    = 3'd5,
    CFG_PREFER_LAST = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [6:0]        match_score;
    logic signed [7:0] mismatch_score;
    logic signed [7:0] gap_open;
    logic signed [7:0] gap_extend;
    logic              start_clip;
    logic              end_clip;
    logic              prefer_last;
  } cfg_t;

  typedef struct packed {
    score_t              score;
    logic [QPOS_W-1:0]   qpos;
    logic [TPOS_W-1:0]   tpos;
    logic [COUNT_W-1:0]  count;
  } best_t;

  localparam best_t BEST_EMPTY = '{score: NEG_FLOOR, qpos: '0, tpos: '0, count: '0};

  typedef struct packed {
    logic              en;
    logic [QPOS_W-1:0] idx;
    logic [SYM_W-1:0]  sym;
  } qwrite_t;

  // one target column travelling down the row of cells
  typedef struct packed {
    logic              valid;
    logic              last;
    logic              en;
    logic              first;
    logic [TPOS_W-1:0] tpos;
    logic [SYM_W-1:0]  sym;
    score_t            m;
    score_t            f;
    score_t            diag;
    score_t            bnd;
    best_t             best;
  } wave_t;

  function automatic score_t smax(score_t a, score_t b);
    return ($signed(a) > $signed(b)) ? a : b;
  endfunction

  // combine two best summaries; order of arrival does not matter
  function automatic best_t best_merge(best_t a, best_t b, logic prefer_last);
    best_t            r;
    logic             b_better;
    logic [COUNT_W:0] sum;
    r = a;
    sum = '0;
    b_better = 1'b0;
    if (b.count == '0) begin
      r = a;
    end else if (a.count == '0) begin
      r = b;
    end else if ($signed(b.score) > $signed(a.score)) begin
      r = b;
    end else if ($signed(a.score) > $signed(b.score)) begin
      r = a;
    end else begin
      if (prefer_last) begin
        b_better = {b.qpos, b.tpos} > {a.qpos, a.tpos};
      end else begin
        b_better = {b.qpos, b.tpos} < {a.qpos, a.tpos};
      end
      r = b_better ? b : a;
      sum = {1'b0, a.count} + {1'b0, b.count};
      r.count = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/ags_if.sv
// ----------------------------------------------------------------------------
// ags channel interfaces
// Input symbol words, result words and register writes, each valid/ready.
// ----------------------------------------------------------------------------
interface ags_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] symbol;
  logic       last;
  modport source (output valid, cmd, symbol, last, input ready);
  modport sink (input valid, cmd, symbol, last, output ready);
endinterface

interface ags_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] score;
  logic [8:0]  row_end;
  logic [9:0]  col_end;
  logic [19:0] best_count;
  modport source (output valid, score, row_end, col_end, best_count, input ready);
  modport sink (input valid, score, row_end, col_end, best_count, output ready);
endinterface

interface ags_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/ags_cell.sv
// ----------------------------------------------------------------------------
// ags_cell: one query row of the scoring array
// Holds its query symbol, H and E of the previous column; passes M, F,
// the diagonal and the running best of the column on to the next row.
// ----------------------------------------------------------------------------
module ags_cell #(
  parameter int Idx        = 0,
  parameter int SymbolBits = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  ags_pkg::cfg_t             regs,
  input  ags_pkg::qwrite_t          qwr,
  input  logic [ags_pkg::QPOS_W:0]  qlen,
  input  logic                      kill,
  input  ags_pkg::wave_t            wave_in,
  output ags_pkg::wave_t            wave_out
);
  import ags_pkg::*;

  logic [SymbolBits-1:0] qsym;
  score_t h_reg;
  score_t e_reg;
  wave_t  wave_next;

  score_t ext, oe, f_cur, e_cur, left, s, m0, m, h;
  logic   active, last_row, upd, considered;
  best_t  cand;

  always_comb begin
    ext = score_t'(regs.gap_extend);
    oe = score_t'(regs.gap_open) + ext;
    active = (QPOS_W+1)'(Idx) < qlen;
    last_row = (QPOS_W+1)'(Idx + 1) == qlen;
    upd = wave_in.valid && wave_in.en && active;
    f_cur = smax(wave_in.f + ext, wave_in.m + oe);
    if (wave_in.first) begin
      e_cur = regs.start_clip ? oe : NEG_FLOOR;
      left = regs.start_clip ? '0 : wave_in.bnd;
    end else begin
      e_cur = e_reg;
      left = h_reg;
    end
    s = (qsym == wave_in.sym[SymbolBits-1:0]) ? score_t'({1'b0, regs.match_score})
                                              : score_t'(regs.mismatch_score);
    m0 = wave_in.diag + s;
    m = (regs.start_clip && m0[SCORE_W-1]) ? '0 : m0;
    h = smax(smax(e_cur, f_cur), m);
    considered = upd && (regs.end_clip || last_row) && ($signed(h) >= $signed(NEG_FLOOR));
    cand = '{score: h, qpos: QPOS_W'(Idx), tpos: wave_in.tpos, count: COUNT_W'(1)};

    wave_next = wave_in;
    wave_next.valid = wave_in.valid && !kill;
    wave_next.bnd = wave_in.bnd + ext;
    if (upd) begin
      wave_next.m = m;
      wave_next.f = f_cur;
      wave_next.diag = left;
    end
    if (considered) begin
      wave_next.best = best_merge(wave_in.best, cand, regs.prefer_last);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_out.valid <= 1'b0;
    end else begin
      wave_out.valid <= wave_next.valid;
    end
    wave_out.last  <= wave_next.last;
    wave_out.en    <= wave_next.en;
    wave_out.first <= wave_next.first;
    wave_out.tpos  <= wave_next.tpos;
    wave_out.sym   <= wave_next.sym;
    wave_out.m     <= wave_next.m;
    wave_out.f     <= wave_next.f;
    wave_out.diag  <= wave_next.diag;
    wave_out.bnd   <= wave_next.bnd;
    wave_out.best  <= wave_next.best;
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      h_reg <= h;
      e_reg <= smax(e_cur + ext, m + oe);
    end
    if (qwr.en && qwr.idx == QPOS_W'(Idx)) begin
      qsym <= qwr.sym[SymbolBits-1:0];
    end
  end

endmodule

FILE: rtl/affine_gap_alignment_scorer_core.sv
// ----------------------------------------------------------------------------
// affine_gap_alignment_scorer_core: affine gap alignment scorer, top level
// Query symbols are loaded into a row of QueryMax cells; each target symbol
// then runs down the row as one column of the score matrix.
// ----------------------------------------------------------------------------
// Channels: items (cmd, symbol, last), results (score, row_end, col_end,
// best_count), cfg (index, data) register writes, always ready.
// Throughput: one input word per cycle, query or target, except while the input
// is held off. Each target column walks the row one cell per clock; the result
// word is registered once the column marked last has left the row, and the input
// is held off from the final target word until then.
// A query word aborts any target in progress: the columns still in the row
// are dropped and the best tracking is cleared.
// Reset: registers to their defaults, empty query, no result pending.
// Receiver stall: the result word is held in the output register; new words
// are still accepted, except a final target word, which waits until the
// pending result has been taken.
// ----------------------------------------------------------------------------
module affine_gap_alignment_scorer_core #(
  parameter int QueryMax   = ags_pkg::QUERY_MAX_DEF,
  parameter int TargetMax  = ags_pkg::TARGET_MAX_DEF,
  parameter int SymbolBits = ags_pkg::SYMBOL_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  ags_in_if.sink    items,
  ags_out_if.source results,
  ags_cfg_if.sink   cfg
);
  import ags_pkg::*;

  localparam int TCW = $clog2(TargetMax + 1);

  cfg_t              regs;
  logic [QPOS_W:0]   qlen;
  logic              q_closed;
  logic [TCW-1:0]    tpos;
  logic              last_inflight;
  best_t             acc;
  logic              res_valid;
  best_t             res;

  wave_t             chain [QueryMax+1];
  qwrite_t           qwr;
  logic              in_acc, q_acc, t_acc;
  logic [QPOS_W:0]   widx;
  best_t             merged;

  assign cfg.ready = 1'b1;
  assign items.ready = !last_inflight && !(res_valid && items.cmd && items.last);
  assign in_acc = items.valid && items.ready;
  assign q_acc = in_acc && !items.cmd;
  assign t_acc = in_acc && items.cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '{match_score: 7'd1, mismatch_score: -8'sd3, gap_open: -8'sd5,
                gap_extend: -8'sd2, start_clip: 1'b0, end_clip: 1'b0,
                prefer_last: 1'b0};
    end else if (cfg.valid) begin
      case (cfg_idx_e'(cfg.index))
        CFG_MATCH:       regs.match_score <= cfg.data[6:0];
        CFG_MISMATCH:    regs.mismatch_score <= cfg.data;
        CFG_GAP_OPEN:    regs.gap_open <= cfg.data;
        CFG_GAP_EXTEND:  regs.gap_extend <= cfg.data;
        CFG_START_CLIP:  regs.start_clip <= cfg.data[0];
        CFG_END_CLIP:    regs.end_clip <= cfg.data[0];
        CFG_PREFER_LAST: regs.prefer_last <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // query load: a closed query restarts at row zero
  always_comb begin
    widx = q_closed ? '0 : qlen;
    qwr.en = q_acc && (widx < (QPOS_W+1)'(QueryMax));
    qwr.idx = widx[QPOS_W-1:0];
    qwr.sym = items.symbol;
  end

  always_comb begin
    chain[0] = '0;
    chain[0].valid = t_acc;
    chain[0].last = items.last;
    chain[0].en = tpos < TCW'(TargetMax);
    chain[0].first = tpos == '0;
    chain[0].tpos = TPOS_W'(tpos);
    chain[0].sym = items.symbol;
    chain[0].m = '0;
    chain[0].f = NEG_FLOOR;
    chain[0].diag = '0;
    chain[0].bnd = score_t'(regs.gap_open) + score_t'(regs.gap_extend);
    chain[0].best = BEST_EMPTY;
  end

  for (genvar g = 0; g < QueryMax; g++) begin : g_cell
    ags_cell #(
      .Idx        (g),
      .SymbolBits (SymbolBits)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .regs     (regs),
      .qwr      (qwr),
      .qlen     (qlen),
      .kill     (q_acc),
      .wave_in  (chain[g]),
      .wave_out (chain[g+1])
    );
  end

  assign merged = best_merge(acc, chain[QueryMax].best, regs.prefer_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      qlen <= '0;
      q_closed <= 1'b1;
      tpos <= '0;
      last_inflight <= 1'b0;
      acc <= BEST_EMPTY;
      res_valid <= 1'b0;
    end else begin
      if (results.valid && results.ready) begin
        res_valid <= 1'b0;
      end
      if (q_acc) begin
        tpos <= '0;
        acc <= BEST_EMPTY;
        q_closed <= items.last;
        if (qwr.en) begin
          qlen <= widx + 1'b1;
        end else if (q_closed) begin
          qlen <= '0;
        end
      end else begin
        if (t_acc) begin
          q_closed <= 1'b1;
          if (items.last) begin
            tpos <= '0;
            last_inflight <= 1'b1;
          end else if (tpos < TCW'(TargetMax)) begin
            tpos <= tpos + 1'b1;
          end
        end
        if (chain[QueryMax].valid) begin
          if (chain[QueryMax].last) begin
            acc <= BEST_EMPTY;
            res <= merged;
            res_valid <= 1'b1;
            last_inflight <= 1'b0;
          end else begin
            acc <= merged;
          end
        end
      end
    end
  end

  assign results.valid = res_valid;
  assign results.score = res.score;
  assign results.row_end = res.qpos[8:0];
  assign results.col_end = res.tpos[9:0];
  assign results.best_count = res.count;

  a_rise_from_exit: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(chain[QueryMax].valid && chain[QueryMax].last))
    else $error("result raised without a final column leaving the row");

  a_one_final: assert property (@(posedge clk) disable iff (rst)
    last_inflight |-> !in_acc)
    else $error("word accepted while a final column is in the row");

  a_empty_floor: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.count == '0 |-> res.score == NEG_FLOOR)
    else $error("empty result carries a score");

  a_kill: assert property (@(posedge clk) disable iff (rst)
    q_acc |=> !chain[1].valid)
    else $error("column survived a query word");

endmodule
